// ----- design/ilid_pkg.sv -----
// shared types and constants for the indexed list block
package ilid_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int LEN_OUT_W    = 7;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] list_position;
    logic signed [DATA_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [LEN_OUT_W-1:0]     list_length;
  } out_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              launch;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- design/ilid_cell.sv -----
// one list entry cell with shift and read-chain stage
module ilid_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ilid_pkg::cell_ctrl_t        ctrl,
  input  logic [IW-1:0]               idx,
  input  logic [ilid_pkg::DATA_W-1:0] left_entry,
  input  logic [ilid_pkg::DATA_W-1:0] right_entry,
  input  logic [ilid_pkg::DATA_W-1:0] rd_in,
  input  logic                        rd_vld_in,
  output logic [ilid_pkg::DATA_W-1:0] entry,
  output logic [ilid_pkg::DATA_W-1:0] rd_data,
  output logic                        rd_vld
);

  localparam logic [IW-1:0] ME = IW'(INDEX);

  logic hit;
  logic above;

  assign hit   = (idx == ME);
  assign above = (ME > idx);

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      ilid_pkg::CMD_INS: begin
        if (hit) begin
          entry <= ctrl.value;
        end else if (above) begin
          entry <= left_entry;
        end
      end
      ilid_pkg::CMD_DEL: begin
        if (hit || above) begin
          entry <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // read token walks toward cell zero, one cell per cycle
  always_ff @(posedge clk) begin
    if (ctrl.launch && hit) begin
      rd_data <= entry;
    end else begin
      rd_data <= rd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (ctrl.launch) begin
      rd_vld <= hit;
    end else begin
      rd_vld <= rd_vld_in;
    end
  end

endmodule

// ----- design/indexed_list_insert_delete_top.sv -----
// top level of the indexed list: control, length and the row of cells
//
// Usage: drive request and raise start; the request transfers at a rising
// edge where start is high and busy is low. Every request gives exactly one
// result, shown on result for one cycle while done is high; the receiver
// cannot stall, so each result must be taken in that cycle.
// Inserts, deletes, unused opcodes and out-of-range reads answer in the cycle
// after the transfer and the block is ready again at once, so these run at
// one request per cycle. An insert or delete shifts all later cells by one
// place in that same cycle.
// A read in range launches a token into the row of cells at the addressed
// cell; it moves one cell per cycle toward cell zero, and the read answers
// once the token has reached cell zero, holding busy high until then; the
// next request can transfer once busy is low again.
// Reset (rst, synchronous) empties the list and drops any read in flight;
// entry contents are not cleared, and are only read after being written.
// list_length reports the entry count in 7 bits.
module indexed_list_insert_delete_top #(
  parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ilid_pkg::in_t  request,
  output logic           done,
  output ilid_pkg::out_t result
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int DW = ilid_pkg::DATA_W;
  localparam logic [LW-1:0] CAP = LW'(CAPACITY);

  ilid_pkg::state_t     state;
  ilid_pkg::state_t     state_next;
  logic [LW-1:0]        len;
  logic [LW-1:0]        len_next;
  logic                 done_next;
  ilid_pkg::out_t       result_next;
  ilid_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]        idx;

  logic                 accept;
  logic                 full;
  logic                 pos_neg;
  logic                 pos_ge_len;
  logic                 pos_gt_len;
  logic [DW-1:0]        len_ext;

  logic [DW-1:0]        ent    [CAPACITY];
  logic [DW-1:0]        rdd    [CAPACITY];
  logic [CAPACITY-1:0]  rdv;

  assign busy     = (state == ilid_pkg::S_READ);
  assign accept   = start && !busy;
  assign full     = (len == CAP);
  assign len_ext  = DW'(len);
  assign pos_neg  = request.list_position[DW-1];
  assign pos_ge_len = pos_neg || ($unsigned(request.list_position) >= len_ext);
  assign pos_gt_len = pos_neg || ($unsigned(request.list_position) > len_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilid_pkg::S_IDLE;
      len   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    len_next    = len;
    done_next   = 1'b0;
    result_next = result;
    ctrl.cmd    = ilid_pkg::CMD_HOLD;
    ctrl.launch = 1'b0;
    ctrl.value  = request.item_value;
    idx         = request.list_position[IW-1:0];

    unique case (state)
      ilid_pkg::S_IDLE: begin
        if (accept) begin
          done_next              = 1'b1;
          result_next.read_value = '0;
          result_next.status     = ilid_pkg::STAT_DONE;
          unique case (request.opcode)
            ilid_pkg::OP_READ: begin
              if (pos_ge_len) begin
                result_next.read_value = '1;
                result_next.status     = ilid_pkg::STAT_RANGE;
              end else begin
                done_next   = 1'b0;
                ctrl.launch = 1'b1;
                state_next  = ilid_pkg::S_READ;
              end
            end
            ilid_pkg::OP_INS_HEAD: begin
              idx = '0;
              if (full) begin
                result_next.status = ilid_pkg::STAT_FULL;
              end else begin
                ctrl.cmd = ilid_pkg::CMD_INS;
                len_next = len + LW'(1);
              end
            end
            ilid_pkg::OP_INS_TAIL: begin
              idx = len[IW-1:0];
              if (full) begin
                result_next.status = ilid_pkg::STAT_FULL;
              end else begin
                ctrl.cmd = ilid_pkg::CMD_INS;
                len_next = len + LW'(1);
              end
            end
            ilid_pkg::OP_INS_AT: begin
              if (pos_gt_len) begin
                result_next.status = ilid_pkg::STAT_RANGE;
              end else if (full) begin
                result_next.status = ilid_pkg::STAT_FULL;
              end else begin
                ctrl.cmd = ilid_pkg::CMD_INS;
                len_next = len + LW'(1);
              end
            end
            ilid_pkg::OP_DELETE: begin
              if (pos_ge_len) begin
                result_next.status = ilid_pkg::STAT_RANGE;
              end else begin
                ctrl.cmd = ilid_pkg::CMD_DEL;
                len_next = len - LW'(1);
              end
            end
            default: begin
            end
          endcase
          result_next.list_length = ilid_pkg::LEN_OUT_W'(len_next);
        end
      end
      ilid_pkg::S_READ: begin
        if (rdv[0]) begin
          done_next               = 1'b1;
          result_next.read_value  = rdd[0];
          result_next.status      = ilid_pkg::STAT_DONE;
          result_next.list_length = ilid_pkg::LEN_OUT_W'(len);
          state_next              = ilid_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ilid_pkg::S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_e;
    logic [DW-1:0] right_e;
    logic [DW-1:0] rd_in;
    logic          rd_vld_in;

    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e   = '0;
      assign rd_in     = '0;
      assign rd_vld_in = 1'b0;
    end else begin : g_mid_r
      assign right_e   = ent[i+1];
      assign rd_in     = rdd[i+1];
      assign rd_vld_in = rdv[i+1];
    end

    ilid_cell #(
      .INDEX (i),
      .IW    (IW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .idx         (idx),
      .left_entry  (left_e),
      .right_entry (right_e),
      .rd_in       (rd_in),
      .rd_vld_in   (rd_vld_in),
      .entry       (ent[i]),
      .rd_data     (rdd[i]),
      .rd_vld      (rdv[i])
    );
  end

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during read walk");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rdv))
    else $error("more than one read token in the cell row");

  a_token_only_busy: assert property (@(posedge clk) disable iff (rst)
    (rdv != '0) |-> busy)
    else $error("read token in flight while idle");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CAP)
    else $error("list length beyond capacity");

endmodule

// ----- tb/indexed_list_insert_delete_top_tb.sv -----
// testbench for the indexed list block: directed and random list operations against a queue model
`timescale 1ns / 1ps

module indexed_list_insert_delete_top_tb;

  localparam int CAP = ilid_pkg::CAPACITY_DEF;
  localparam int DW = ilid_pkg::DATA_W;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic signed [DW-1:0] INT_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] INT_MIN = 32'sh80000000;
  localparam logic signed [DW-1:0] MISS_VALUE = -32'sd1;
  localparam int DRAIN_CYCLES = CAP + 4;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  ilid_pkg::in_t request;
  logic done;
  ilid_pkg::out_t result;

  logic [DW-1:0] list_model[$];
  ilid_pkg::out_t pending_results[$];
  int idle_pct = 0;
  int n_fail = 0;
  int n_transfers = 0;
  int n_checked = 0;
  int n_read_hits = 0;
  int n_range = 0;
  int n_full = 0;

  indexed_list_insert_delete_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic ilid_pkg::in_t mk_req(logic [2:0] op, logic signed [DW-1:0] pos,
                                           logic signed [DW-1:0] val);
    ilid_pkg::in_t r;
    r.opcode = op;
    r.list_position = pos;
    r.item_value = val;
    return r;
  endfunction

  // applies one list operation to the model and returns the result it should give
  function automatic ilid_pkg::out_t apply_list_op(ilid_pkg::in_t req);
    ilid_pkg::out_t r;
    int len;
    len = list_model.size();
    r.read_value = '0;
    r.status = ilid_pkg::STAT_DONE;
    case (req.opcode)
      ilid_pkg::OP_READ: begin
        if (req.list_position < 0 || req.list_position >= len) begin
          r.read_value = MISS_VALUE;
          r.status = ilid_pkg::STAT_RANGE;
        end else begin
          r.read_value = list_model[req.list_position];
          n_read_hits++;
        end
      end
      ilid_pkg::OP_INS_HEAD: begin
        if (len >= CAP) r.status = ilid_pkg::STAT_FULL;
        else list_model.push_front(req.item_value);
      end
      ilid_pkg::OP_INS_TAIL: begin
        if (len >= CAP) r.status = ilid_pkg::STAT_FULL;
        else list_model.push_back(req.item_value);
      end
      ilid_pkg::OP_INS_AT: begin
        if (req.list_position < 0 || req.list_position > len) r.status = ilid_pkg::STAT_RANGE;
        else if (len >= CAP) r.status = ilid_pkg::STAT_FULL;
        else list_model.insert(req.list_position, req.item_value);
      end
      ilid_pkg::OP_DELETE: begin
        if (req.list_position < 0 || req.list_position >= len) r.status = ilid_pkg::STAT_RANGE;
        else list_model.delete(req.list_position);
      end
      default: begin
      end
    endcase
    if (r.status == ilid_pkg::STAT_RANGE) n_range++;
    if (r.status == ilid_pkg::STAT_FULL) n_full++;
    r.list_length = ilid_pkg::LEN_OUT_W'(list_model.size());
    return r;
  endfunction

  task automatic send_request(input ilid_pkg::in_t req);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_op(req));
    n_transfers++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] pick_position();
    int unsigned r;
    int len;
    len = list_model.size();
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, len);
    else if (r < 92) return -$signed(DW'($urandom_range(1, 3)));
    else if (r < 96) return len + $urandom_range(1, 3);
    else return $urandom();
  endfunction

  function automatic ilid_pkg::in_t random_request(int ins_pct);
    int unsigned r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end else if (r < 30) begin
      op = ilid_pkg::OP_READ;
    end else if ($urandom_range(0, 99) < ins_pct) begin
      case ($urandom_range(0, 2))
        0: op = ilid_pkg::OP_INS_HEAD;
        1: op = ilid_pkg::OP_INS_TAIL;
        default: op = ilid_pkg::OP_INS_AT;
      endcase
    end else begin
      op = ilid_pkg::OP_DELETE;
    end
    return mk_req(op, pick_position(), $urandom());
  endfunction

  task automatic test_directed();
    send_request(mk_req(ilid_pkg::OP_READ, 0, $urandom()));
    send_request(mk_req(ilid_pkg::OP_READ, MISS_VALUE, $urandom()));
    send_request(mk_req(ilid_pkg::OP_READ, INT_MIN, $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, 0, $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, 1, $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, MISS_VALUE, $urandom()));
    for (logic [3:0] op = {1'b0, OP_UNUSED_LO}; op <= {1'b0, OP_UNUSED_HI}; op++)
      send_request(mk_req(op[2:0], $urandom(), $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, 0, INT_MAX));
    send_request(mk_req(ilid_pkg::OP_INS_HEAD, $urandom(), INT_MIN));
    send_request(mk_req(ilid_pkg::OP_INS_TAIL, $urandom(), MISS_VALUE));
    send_request(mk_req(ilid_pkg::OP_INS_AT, 1, '0));
    send_request(mk_req(ilid_pkg::OP_INS_AT, list_model.size(), 32'sh55555555));
    for (int i = 0; i <= list_model.size(); i++)
      send_request(mk_req(ilid_pkg::OP_READ, i, $urandom()));
    send_request(mk_req(ilid_pkg::OP_READ, INT_MAX, $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, INT_MAX, $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, INT_MIN, $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, 1, $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, 0, $urandom()));
    send_request(mk_req(ilid_pkg::OP_READ, 0, $urandom()));
  endtask

  task automatic test_full_list();
    while (list_model.size() < CAP)
      send_request(mk_req(ilid_pkg::OP_INS_TAIL, $urandom(), $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_HEAD, $urandom(), $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_TAIL, $urandom(), $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, 0, $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, CAP, $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, CAP + 1, $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, MISS_VALUE, $urandom()));
    send_request(mk_req(ilid_pkg::OP_READ, CAP - 1, $urandom()));
    send_request(mk_req(ilid_pkg::OP_READ, CAP, $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, CAP - 1, $urandom()));
    send_request(mk_req(ilid_pkg::OP_INS_AT, CAP - 1, $urandom()));
    while (list_model.size() != 0)
      send_request(mk_req(ilid_pkg::OP_DELETE, $urandom_range(0, list_model.size() - 1),
                          $urandom()));
    send_request(mk_req(ilid_pkg::OP_DELETE, 0, $urandom()));
  endtask

  task automatic test_random(int gap_pct, int ins_pct, int count);
    idle_pct = gap_pct;
    repeat (count) send_request(random_request(ins_pct));
    wait_all_results();
  endtask

  always @(posedge clk) begin : check_results
    ilid_pkg::out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer pending: read_value %0d status %0d list_length %0d",
               result.read_value, result.status, result.list_length);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, result.read_value);
          n_fail++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          n_fail++;
        end
        if (result.list_length !== want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length, result.list_length);
          n_fail++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_list();
    test_random(0, 70, 280);
    test_random(59, 60, 280);
    test_random(27, 30, 280);
    test_random(59, 50, 280);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_fail++;
    end
    $display("ran %0d transfers: %0d reads in range, %0d out-of-range flags, %0d full drops",
             n_transfers, n_read_hits, n_range, n_full);
    $display("checked %0d results with the sender idle at 0, 27 and 59 percent", n_checked);
    if (n_fail == 0) begin
      $display("indexed_list_insert_delete_top_tb passed");
    end else begin
      $display("indexed_list_insert_delete_top_tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("indexed_list_insert_delete_top_tb failed");
    $finish;
  end

endmodule
